// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/lkv_pkg.sv =====
package lkv_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int CFG_WIDTH     = 5;
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_KEY_WIDTH = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_WIDTH-1:0] CAP_RESET = 5'd16;

    // Request actions
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // One request as it travels from the front queue to the engine
    typedef struct packed {
        logic                  action;
        logic [DATA_WIDTH-1:0] key;
        logic [DATA_WIDTH-1:0] value;
    } req_t;

endpackage

// ===== sv/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Request channel: drive action (0 get, 1 put), lookup_key and store_value
// with start high; the request is taken at a clock edge where busy is low.
// A two-entry request queue sits in front of the lookup engine, so busy is
// only high when that queue is full.
// Result channel: done is high for one cycle with hit, read_value, evicted
// and evicted_key; the receiver cannot hold results off.
// A request passes the queue slot, the classified-operation registers and the
// result registers; the engine takes no new request while it holds one, due to
// its classify-then-update step on the shared entry table.
// Capacity: cfg_write_data is written on an edge with cfg_write_en high; it
// resets to 16, zero acts as 1, values above the entry count saturate.
// Write it only while no request is outstanding.
// Reset clears all valid marks, the occupancy and the queue at once; the
// block takes requests right after reset.
`include "assert_macros.svh"

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic signed [DATA_WIDTH-1:0] lookup_key,
    input  logic signed [DATA_WIDTH-1:0] store_value,
    input  logic                         cfg_write_en,
    input  logic        [CFG_WIDTH-1:0]  cfg_write_data,
    output logic                         done,
    output logic                         hit,
    output logic signed [DATA_WIDTH-1:0] read_value,
    output logic                         evicted,
    output logic signed [DATA_WIDTH-1:0] evicted_key
);

    logic [CFG_WIDTH-1:0]  capacity_reg;
    req_t                  push_req;
    req_t                  head_req;
    logic                  head_valid;
    logic                  head_ready;
    logic                  queue_full;
    logic [DATA_WIDTH-1:0] read_value_raw;
    logic [DATA_WIDTH-1:0] evicted_key_raw;

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            capacity_reg <= cfg_write_data;
        end
    end

    // Pack the incoming request
    always_comb
    begin
        push_req.action = action;
        push_req.key    = lookup_key;
        push_req.value  = store_value;
    end

    assign busy = queue_full;

    lkv_req_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (start),
        .push_req   (push_req),
        .full       (queue_full),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_req    (head_req)
    );

    lkv_engine #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .req_valid   (head_valid),
        .req         (head_req),
        .req_ready   (head_ready),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value_raw),
        .evicted     (evicted),
        .evicted_key (evicted_key_raw)
    );

    assign read_value  = read_value_raw;
    assign evicted_key = evicted_key_raw;

    `ASSERT_NEXT(a_done_spacing, clk, rst_n, done, !done, "results closer than two cycles")
    `ASSERT_IMPLY(a_evict_on_miss, clk, rst_n, done && evicted, !hit, "eviction on a hit")
    `ASSERT_IMPLY(a_read_needs_hit, clk, rst_n, done && (read_value != '0), hit && !evicted, "read value without a get hit")
    `ASSERT_IMPLY(a_busy_from_push, clk, rst_n, $rose(busy), $past(start), "queue filled without a request")

endmodule

// ===== sv/lkv_req_queue.sv =====
module lkv_req_queue
    import lkv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  req_t push_req,
    output logic full,
    output logic pop_valid,
    input  logic pop_ready,
    output req_t pop_req
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_req   = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Store an incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/lkv_engine.sv =====
module lkv_engine
    import lkv_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CFG_WIDTH-1:0]  capacity,
    input  logic                  req_valid,
    input  req_t                  req,
    output logic                  req_ready,
    output logic                  done,
    output logic                  hit,
    output logic [DATA_WIDTH-1:0] read_value,
    output logic                  evicted,
    output logic [DATA_WIDTH-1:0] evicted_key
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;

    // Entry table
    logic [KEY_WIDTH-1:0]  entry_key_reg   [ENTRIES];
    logic [DATA_WIDTH-1:0] entry_value_reg [ENTRIES];
    logic [RANK_W-1:0]     entry_rank_reg  [ENTRIES];
    logic [ENTRIES-1:0]    entry_valid_reg;
    logic [CNT_W-1:0]      occupied_reg;

    // Classified operation waiting to execute
    logic                  op_valid_reg;
    logic                  op_action_reg;
    logic [KEY_WIDTH-1:0]  op_key_reg;
    logic [DATA_WIDTH-1:0] op_value_reg;
    logic                  op_hit_reg;
    logic                  op_evict_reg;
    logic                  op_insert_reg;
    logic [IDX_W-1:0]      op_idx_reg;
    logic [CNT_W-1:0]      op_old_rank_reg;

    // Result registers
    logic                  done_reg;
    logic                  hit_reg;
    logic [DATA_WIDTH-1:0] read_value_reg;
    logic                  evicted_reg;
    logic [DATA_WIDTH-1:0] evicted_key_reg;

    logic [KEY_WIDTH-1:0]  head_key;
    logic [DATA_WIDTH-1:0] victim_key_ext;
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    oldest_vec;
    logic                  hit_any;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [RANK_W-1:0]     last_rank;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      cap_eff;
    logic                  table_full;
    logic                  take;
    logic                  touch;

    // Fit the 32-bit request key to the stored key width
    if (KEY_WIDTH > DATA_WIDTH)
    begin : g_key_wide
        assign head_key       = {{(KEY_WIDTH - DATA_WIDTH){1'b0}}, req.key};
        assign victim_key_ext = entry_key_reg[op_idx_reg][DATA_WIDTH-1:0];
    end
    else if (KEY_WIDTH == DATA_WIDTH)
    begin : g_key_same
        assign head_key       = req.key;
        assign victim_key_ext = entry_key_reg[op_idx_reg];
    end
    else
    begin : g_key_narrow
        assign head_key       = req.key[KEY_WIDTH-1:0];
        assign victim_key_ext = {{(DATA_WIDTH - KEY_WIDTH){1'b0}}, entry_key_reg[op_idx_reg]};
    end

    assign req_ready = !op_valid_reg;
    assign take      = req_valid && req_ready;
    assign touch     = op_hit_reg || op_evict_reg || op_insert_reg;

    // Classify the head request against the table
    always_comb
    begin
        last_rank = RANK_W'(occupied_reg - CNT_W'(1));
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = entry_valid_reg[i] && (entry_key_reg[i] == head_key);
            oldest_vec[i] = entry_valid_reg[i] && (entry_rank_reg[i] == last_rank);
        end
        hit_any    = |match_vec;
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!entry_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (oldest_vec[i])
            begin
                victim_idx = IDX_W'(i);
            end
        end
        cap_ext = CMP_W'(capacity);
        cap_eff = cap_ext;
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        table_full = (CMP_W'(occupied_reg) >= cap_eff);
    end

    // Hold the classified operation
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_action_reg <= req.action;
            op_key_reg    <= head_key;
            op_value_reg  <= req.value;
            op_hit_reg    <= hit_any;
            op_evict_reg  <= !hit_any && (req.action == ACT_PUT) && table_full;
            op_insert_reg <= !hit_any && (req.action == ACT_PUT) && !table_full;
            if (hit_any)
            begin
                op_idx_reg      <= hit_idx;
                op_old_rank_reg <= CNT_W'(entry_rank_reg[hit_idx]);
            end
            else
            begin
                op_idx_reg      <= table_full ? victim_idx : free_idx;
                op_old_rank_reg <= occupied_reg;
            end
        end
    end

    // Update key, value and rank of the entries
    always_ff @(posedge clk)
    begin
        if (op_valid_reg && touch)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_W'(i) == op_idx_reg)
                begin
                    entry_rank_reg[i] <= '0;
                    if (op_action_reg == ACT_PUT)
                    begin
                        entry_value_reg[i] <= op_value_reg;
                    end
                    if (op_evict_reg || op_insert_reg)
                    begin
                        entry_key_reg[i] <= op_key_reg;
                    end
                end
                else if (entry_valid_reg[i] &&
                         (CNT_W'(entry_rank_reg[i]) < op_old_rank_reg))
                begin
                    entry_rank_reg[i] <= entry_rank_reg[i] + 1'b1;
                end
            end
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (op_valid_reg)
        begin
            hit_reg         <= op_hit_reg;
            read_value_reg  <= (op_hit_reg && (op_action_reg == ACT_GET))
                               ? entry_value_reg[op_idx_reg] : '0;
            evicted_reg     <= op_evict_reg;
            evicted_key_reg <= op_evict_reg ? victim_key_ext : '0;
        end
    end

    // Control state: valid marks, occupancy, stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            occupied_reg    <= '0;
            op_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= op_valid_reg;
            if (take)
            begin
                op_valid_reg <= 1'b1;
            end
            else if (op_valid_reg)
            begin
                op_valid_reg <= 1'b0;
            end
            if (op_valid_reg && op_insert_reg)
            begin
                entry_valid_reg[op_idx_reg] <= 1'b1;
                occupied_reg                <= occupied_reg + 1'b1;
            end
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule
